// ===== sv/pfe_pkg.sv =====
// Shared types and constants of the palette fade engine.
`default_nettype none

package pfe_pkg;

  // Host action codes
  localparam logic [2:0] ACT_WR_CUR = 3'd0;
  localparam logic [2:0] ACT_WR_TGT = 3'd1;
  localparam logic [2:0] ACT_RD_CUR = 3'd2;
  localparam logic [2:0] ACT_START  = 3'd3;
  localparam logic [2:0] ACT_TICK   = 3'd4;

  // Fade kinds; zero means no fade running
  localparam logic [2:0] FADE_NONE = 3'd0;
  localparam logic [2:0] FADE_IN   = 3'd1;
  localparam logic [2:0] FADE_OUT  = 3'd2;
  localparam logic [2:0] FLASH_IN  = 3'd3;
  localparam logic [2:0] FLASH_OUT = 3'd4;

  // Channel step and flash level
  localparam logic [7:0] STEP  = 8'd32;
  localparam logic [7:0] WHITE = 8'd224;

  // Configuration register indexes
  localparam logic REG_SINGLE_BANK = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } pfe_state_e;

  typedef enum logic [1:0] {
    SRC_HOST,
    SRC_ZERO,
    SRC_WHITE,
    SRC_STEP
  } pfe_src_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic       rd_en;
    logic       cur_we;
    logic       tgt_we;
    pfe_src_e   wr_src;
    logic [2:0] mode;
    logic       res_load;
    logic       res_rdata;
    logic       res_done;
  } pfe_cmd_t;

endpackage

`default_nettype wire

// ===== sv/pfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/pfe_ctrl.sv =====
// Controller of the palette fade engine: item sequencing, fade state and entry scans.
`default_nettype none

module pfe_ctrl #(
  parameter int PALETTE_ENTRIES = 64,
  parameter int FADE_FRAMES     = 22
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [2:0]                           action_i,
  input  wire logic                                 bank_i,
  input  wire logic [5:0]                           entry_i,
  input  wire logic [23:0]                          colour_i,
  input  wire logic [2:0]                           fade_kind_i,
  input  wire logic [5:0]                           first_entry_i,
  input  wire logic [5:0]                           last_offset_i,
  input  wire logic                                 single_bank_i,
  input  wire logic                                 out_free_i,
  output pfe_pkg::pfe_cmd_t                         cmd_o,
  output logic [$clog2(2*PALETTE_ENTRIES)-1:0]      rd_addr_o,
  output logic [$clog2(2*PALETTE_ENTRIES)-1:0]      wr_addr_o,
  output logic [23:0]                               colour_o
);

  localparam int IW = $clog2(PALETTE_ENTRIES);
  localparam int AW = $clog2(2 * PALETTE_ENTRIES);
  localparam int CW = ((IW > 7) ? IW : 7) + 1;
  localparam int FW = $clog2(FADE_FRAMES + 1);
  localparam logic [CW-1:0] LAST_C   = CW'(PALETTE_ENTRIES - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(PALETTE_ENTRIES);
  localparam logic [FW-1:0] FRAMES_C = FW'(FADE_FRAMES);

  // Bank 1 sits above bank 0
  function automatic logic [AW-1:0] pal_addr(input logic b, input logic [IW-1:0] idx);
    pal_addr = b ? (AW'(PALETTE_ENTRIES) + AW'(idx)) : AW'(idx);
  endfunction

  pfe_pkg::pfe_state_e state_q, state_d;
  logic [2:0]          mode_q, mode_d;
  logic [FW-1:0]       frame_q, frame_d;
  logic [IW-1:0]       rfirst_q, rfirst_d;
  logic [IW-1:0]       rlast_q, rlast_d;
  logic                rempty_q, rempty_d;
  logic [IW-1:0]       cnt_q, cnt_d;
  logic                sbank_q, sbank_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pend_addr_q, pend_addr_d;
  logic                done_q, done_d;

  // Latched item
  logic [2:0]  act_q;
  logic        bank_q;
  logic [5:0]  entry_q;
  logic [23:0] colour_q;
  logic [2:0]  kind_q;
  logic [5:0]  first_q;
  logic [5:0]  offs_q;

  logic          accept;
  logic [CW-1:0] entry_c, first_c, sum_c, lim_c;
  logic          entry_ok, kind_ok, mode_active, both_banks, cnt_end;
  logic [AW-1:0] host_addr, scan_addr;
  logic [FW-1:0] frame_inc;

  assign in_ready_o = (state_q == pfe_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign colour_o   = colour_q;

  assign entry_c     = CW'(entry_q);
  assign entry_ok    = entry_c < DEPTH_C;
  assign host_addr   = pal_addr(bank_q, entry_c[IW-1:0]);
  assign first_c     = CW'(first_q);
  assign sum_c       = first_c + CW'(offs_q);
  assign lim_c       = (sum_c > LAST_C) ? LAST_C : sum_c;
  assign kind_ok     = kind_q inside {pfe_pkg::FADE_IN, pfe_pkg::FADE_OUT,
                                      pfe_pkg::FLASH_IN, pfe_pkg::FLASH_OUT};
  assign mode_active = mode_q inside {pfe_pkg::FADE_IN, pfe_pkg::FADE_OUT,
                                      pfe_pkg::FLASH_IN, pfe_pkg::FLASH_OUT};
  assign both_banks  = !(((mode_q == pfe_pkg::FADE_IN) || (mode_q == pfe_pkg::FLASH_IN))
                         && single_bank_i);
  assign cnt_end     = (cnt_q == rlast_q);
  assign scan_addr   = pal_addr(sbank_q, cnt_q);
  assign frame_inc   = frame_q + FW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfe_pkg::ST_IDLE: begin
        if (accept) state_d = pfe_pkg::ST_EXEC;
      end
      pfe_pkg::ST_EXEC: begin
        state_d = pfe_pkg::ST_FINISH;
        if (act_q == pfe_pkg::ACT_START) begin
          if ((kind_q == pfe_pkg::FADE_IN && !(first_c > lim_c)) ||
              kind_q == pfe_pkg::FLASH_IN) begin
            state_d = pfe_pkg::ST_CLEAR;
          end
        end else if (act_q == pfe_pkg::ACT_TICK && mode_active) begin
          state_d = rempty_q ? pfe_pkg::ST_DRAIN : pfe_pkg::ST_SCAN;
        end
      end
      pfe_pkg::ST_CLEAR: begin
        if (cnt_end) state_d = pfe_pkg::ST_FINISH;
      end
      pfe_pkg::ST_SCAN: begin
        if (cnt_end && !(!sbank_q && both_banks)) state_d = pfe_pkg::ST_DRAIN;
      end
      pfe_pkg::ST_DRAIN: begin
        state_d = pfe_pkg::ST_FINISH;
      end
      pfe_pkg::ST_FINISH: begin
        if (out_free_i) state_d = pfe_pkg::ST_IDLE;
      end
      default: state_d = pfe_pkg::ST_IDLE;
    endcase
  end

  // Fade state, scan counter and write-back pipe
  always_comb begin
    mode_d      = mode_q;
    frame_d     = frame_q;
    rfirst_d    = rfirst_q;
    rlast_d     = rlast_q;
    rempty_d    = rempty_q;
    cnt_d       = cnt_q;
    sbank_d     = sbank_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    done_d      = done_q;
    case (state_q)
      pfe_pkg::ST_IDLE: begin
        if (accept) done_d = 1'b0;
      end
      pfe_pkg::ST_EXEC: begin
        if (act_q == pfe_pkg::ACT_START && kind_ok) begin
          mode_d  = kind_q;
          frame_d = '0;
          if (kind_q == pfe_pkg::FADE_IN) begin
            rfirst_d = first_c[IW-1:0];
            rlast_d  = lim_c[IW-1:0];
            rempty_d = first_c > lim_c;
            cnt_d    = first_c[IW-1:0];
          end else begin
            rfirst_d = '0;
            rlast_d  = LAST_C[IW-1:0];
            rempty_d = 1'b0;
            cnt_d    = '0;
          end
        end else if (act_q == pfe_pkg::ACT_TICK) begin
          if (!mode_active) begin
            done_d = 1'b1;
          end else begin
            cnt_d   = rfirst_q;
            sbank_d = 1'b0;
          end
        end
      end
      pfe_pkg::ST_CLEAR: begin
        if (!cnt_end) cnt_d = cnt_q + IW'(1);
      end
      pfe_pkg::ST_SCAN: begin
        pend_d      = 1'b1;
        pend_addr_d = scan_addr;
        if (cnt_end) begin
          if (!sbank_q && both_banks) begin
            sbank_d = 1'b1;
            cnt_d   = rfirst_q;
          end
        end else begin
          cnt_d = cnt_q + IW'(1);
        end
      end
      pfe_pkg::ST_DRAIN: begin
        if (frame_inc >= FRAMES_C) begin
          frame_d = '0;
          mode_d  = pfe_pkg::FADE_NONE;
          done_d  = 1'b1;
        end else begin
          frame_d = frame_inc;
        end
      end
      default: ;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o           = '0;
    cmd_o.wr_src    = pfe_pkg::SRC_HOST;
    cmd_o.mode      = mode_q;
    rd_addr_o       = host_addr;
    wr_addr_o       = host_addr;
    case (state_q)
      pfe_pkg::ST_EXEC: begin
        case (act_q)
          pfe_pkg::ACT_WR_CUR: cmd_o.cur_we = entry_ok;
          pfe_pkg::ACT_WR_TGT: cmd_o.tgt_we = entry_ok;
          pfe_pkg::ACT_RD_CUR: cmd_o.rd_en  = entry_ok;
          default: ;
        endcase
      end
      pfe_pkg::ST_CLEAR: begin
        cmd_o.cur_we = 1'b1;
        cmd_o.wr_src = (mode_q == pfe_pkg::FADE_IN) ? pfe_pkg::SRC_ZERO : pfe_pkg::SRC_WHITE;
        wr_addr_o    = pal_addr(1'b0, cnt_q);
      end
      pfe_pkg::ST_SCAN: begin
        cmd_o.rd_en  = 1'b1;
        rd_addr_o    = scan_addr;
        cmd_o.cur_we = pend_q;
        cmd_o.wr_src = pfe_pkg::SRC_STEP;
        wr_addr_o    = pend_addr_q;
      end
      pfe_pkg::ST_DRAIN: begin
        cmd_o.cur_we = pend_q;
        cmd_o.wr_src = pfe_pkg::SRC_STEP;
        wr_addr_o    = pend_addr_q;
      end
      pfe_pkg::ST_FINISH: begin
        cmd_o.res_load  = out_free_i;
        cmd_o.res_rdata = (act_q == pfe_pkg::ACT_RD_CUR) && entry_ok;
        cmd_o.res_done  = done_q;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pfe_pkg::ST_IDLE;
      mode_q   <= pfe_pkg::FADE_NONE;
      frame_q  <= '0;
      rfirst_q <= '0;
      rlast_q  <= LAST_C[IW-1:0];
      rempty_q <= 1'b0;
      cnt_q    <= '0;
      sbank_q  <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      frame_q  <= frame_d;
      rfirst_q <= rfirst_d;
      rlast_q  <= rlast_d;
      rempty_q <= rempty_d;
      cnt_q    <= cnt_d;
      sbank_q  <= sbank_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  // Capture the accepted word and the write-back address
  always_ff @(posedge clk_i) begin
    pend_addr_q <= pend_addr_d;
    if (accept) begin
      act_q    <= action_i;
      bank_q   <= bank_i;
      entry_q  <= entry_i;
      colour_q <= colour_i;
      kind_q   <= fade_kind_i;
      first_q  <= first_entry_i;
      offs_q   <= last_offset_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pfe_dpath.sv =====
// Datapath of the palette fade engine: palette memories, channel step and result register.
`default_nettype none

module pfe_dpath #(
  parameter int PALETTE_ENTRIES = 64
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire pfe_pkg::pfe_cmd_t                    cmd_i,
  input  wire logic [$clog2(2*PALETTE_ENTRIES)-1:0] rd_addr_i,
  input  wire logic [$clog2(2*PALETTE_ENTRIES)-1:0] wr_addr_i,
  input  wire logic [23:0]                          colour_i,
  output logic                                      out_free_o,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [31:0]                               out_data_o
);

  localparam int DEPTH = 2 * PALETTE_ENTRIES;

  // One channel moves by a step toward the target or toward an extreme
  function automatic logic [23:0] step_entry(input logic [23:0] cur,
                                             input logic [23:0] tgt,
                                             input logic [2:0]  mode);
    logic [23:0] r;
    logic [7:0]  c;
    logic [7:0]  t;
    logic        hit;
    int          k;
    r   = cur;
    hit = 1'b0;
    case (mode)
      pfe_pkg::FADE_IN, pfe_pkg::FLASH_IN: begin
        if (cur != tgt) begin
          for (k = 0; k < 3; k++) begin
            c = cur[8*k +: 8];
            t = tgt[8*k +: 8];
            if (!hit && ((mode == pfe_pkg::FADE_IN) ? (t > c) : (t < c))) begin
              r[8*k +: 8] = (mode == pfe_pkg::FADE_IN) ? c + pfe_pkg::STEP
                                                       : c - pfe_pkg::STEP;
              hit = 1'b1;
            end
          end
        end
      end
      pfe_pkg::FADE_OUT: begin
        for (k = 2; k >= 0; k--) begin
          c = cur[8*k +: 8];
          if (!hit && (c != 8'd0)) begin
            r[8*k +: 8] = c - pfe_pkg::STEP;
            hit = 1'b1;
          end
        end
      end
      default: begin
        for (k = 2; k >= 0; k--) begin
          c = cur[8*k +: 8];
          if (!hit && (c != pfe_pkg::WHITE)) begin
            r[8*k +: 8] = c + pfe_pkg::STEP;
            hit = 1'b1;
          end
        end
      end
    endcase
    step_entry = r;
  endfunction

  logic [23:0] cur_rdata, tgt_rdata, cur_wdata, res_rgb;
  logic        out_valid_q;
  logic [31:0] out_data_q;

  // Select the current palette write value
  always_comb begin
    case (cmd_i.wr_src)
      pfe_pkg::SRC_HOST:  cur_wdata = colour_i;
      pfe_pkg::SRC_ZERO:  cur_wdata = '0;
      pfe_pkg::SRC_WHITE: cur_wdata = {pfe_pkg::WHITE, pfe_pkg::WHITE, pfe_pkg::WHITE};
      default:            cur_wdata = step_entry(cur_rdata, tgt_rdata, cmd_i.mode);
    endcase
  end

  pfe_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_cur_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.cur_we),
    .waddr_i (wr_addr_i),
    .wdata_i (cur_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (cur_rdata)
  );

  pfe_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_tgt_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.tgt_we),
    .waddr_i (wr_addr_i),
    .wdata_i (colour_i),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (tgt_rdata)
  );

  assign res_rgb    = cmd_i.res_rdata ? cur_rdata : 24'd0;
  assign out_free_o = !out_valid_q || out_ready_i;

  // Result word register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Pack blue, green, red reversed into red low byte order
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      out_data_q <= {7'd0, cmd_i.res_done, res_rgb[7:0], res_rgb[15:8], res_rgb[23:16]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== sv/palette_fade_engine.sv =====
// A write, read or ignored word passes from accept through the execute and finish states to
// its result; a fade start first clears its entries (the range for fade-in, PALETTE_ENTRIES
// for flash-in); a frame tick scans its range on one or both banks, then drains the write-back.
// Throughput: one word in work at a time; the next word can be accepted in the cycle after the
// result is loaded, and a result not yet taken holds the engine until the output frees.
// Reset clears fade state and handshakes; palette memories hold undefined values until written.
`default_nettype none

module palette_fade_engine #(
  parameter int PALETTE_ENTRIES = 64,
  parameter int FADE_FRAMES     = 22
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // bank[0], entry[6:1], red[14:7], green[22:15], blue[30:23], fade_kind[33:31],
  // first_entry[39:34], last_offset[45:40], zero fill[47:46]
  input  wire logic [47:0] s_axis_tdata,
  // action[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // read_red[7:0], read_green[15:8], read_blue[23:16], fade_done[24], zero fill[31:25]
  output logic [31:0]      m_axis_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(2 * PALETTE_ENTRIES);

  pfe_pkg::pfe_cmd_t cmd;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [23:0]       colour;
  logic              out_free;
  logic              single_bank_q;
  logic              reg_hit;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == pfe_pkg::REG_SINGLE_BANK);
  assign prdata  = reg_hit ? {31'd0, single_bank_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      single_bank_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      single_bank_q <= pwdata[0];
    end
  end

  pfe_ctrl #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES),
    .FADE_FRAMES     (FADE_FRAMES)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .action_i      (s_axis_tuser),
    .bank_i        (s_axis_tdata[0]),
    .entry_i       (s_axis_tdata[6:1]),
    .colour_i      ({s_axis_tdata[14:7], s_axis_tdata[22:15], s_axis_tdata[30:23]}),
    .fade_kind_i   (s_axis_tdata[33:31]),
    .first_entry_i (s_axis_tdata[39:34]),
    .last_offset_i (s_axis_tdata[45:40]),
    .single_bank_i (single_bank_q),
    .out_free_i    (out_free),
    .cmd_o         (cmd),
    .rd_addr_o     (rd_addr),
    .wr_addr_o     (wr_addr),
    .colour_o      (colour)
  );

  pfe_dpath #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .rd_addr_i   (rd_addr),
    .wr_addr_i   (wr_addr),
    .colour_i    (colour),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // One word in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a word is in work");

  // Write-back never collides with the scan read
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en && cmd.cur_we |-> rd_addr != wr_addr)
    else $error("palette read and write at the same address");

  // Current and target memories are never written together
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.cur_we && cmd.tgt_we))
    else $error("current and target written in one cycle");

  // A done flag never comes with colour data
  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[24] |-> m_axis_tdata[23:0] == 24'd0)
    else $error("fade done result carries colour data");

endmodule

`default_nettype wire

// ===== tb/palette_fade_engine_tb.sv =====
// Self-checking testbench for the palette fade engine: random host words against a predictor.
`timescale 1ns / 100ps

module palette_fade_engine_tb;

  localparam int ENTRIES    = 64;
  localparam int LAST_ENTRY = ENTRIES - 1;
  localparam int FADE_TICKS = 22;
  localparam int PHASE_WORDS = 170;
  localparam logic [2:0] REG_ADDR = {pfe_pkg::REG_SINGLE_BANK, 2'b00};

  // Actions and fade kinds that the block must ignore
  localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI  = 3'd7;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;

  // Host word as carried on s_axis_tdata, lowest field last
  typedef struct packed {
    logic [1:0] fill;
    logic [5:0] last_offset;
    logic [5:0] first_entry;
    logic [2:0] fade_kind;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [5:0] entry;
    logic       bank;
  } host_word_t;

  // Reply word as carried on m_axis_tdata
  typedef struct packed {
    logic [6:0] fill;
    logic       done;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } reply_t;

  typedef struct {
    logic [2:0] action;
    host_word_t word;
  } host_item_t;

  // Palette state mirror and queue of replies still owed by the block
  class fade_scoreboard;
    logic [23:0] cur_pal [2*ENTRIES];
    logic [23:0] tgt_pal [2*ENTRIES];
    logic [2:0]  mode;
    int unsigned frames;
    int unsigned rng_first;
    int unsigned rng_last;
    bit          single_bank;
    reply_t      pending_replies[$];
    int unsigned mismatches;
    int unsigned replies_seen;

    function new();
      foreach (cur_pal[i]) begin
        cur_pal[i] = '0;
        tgt_pal[i] = '0;
      end
      mode = pfe_pkg::FADE_NONE;
      frames = 0;
      rng_first = 0;
      rng_last = LAST_ENTRY;
      single_bank = 1'b0;
      mismatches = 0;
      replies_seen = 0;
    endfunction

    function void flag(string msg);
      if (mismatches < 10) $display("mismatch: %s", msg);
      mismatches++;
    endfunction

    // Move one channel a step toward the target: blue, green, red
    function logic [23:0] step_toward(logic [23:0] c, logic [23:0] t, bit up);
      logic [23:0] res;
      logic [7:0]  cc;
      logic [7:0]  tc;
      res = c;
      if (c == t) return c;
      for (int k = 0; k < 3; k++) begin
        cc = c[8*k +: 8];
        tc = t[8*k +: 8];
        if (up ? (tc > cc) : (tc < cc)) begin
          res[8*k +: 8] = up ? cc + pfe_pkg::STEP : cc - pfe_pkg::STEP;
          return res;
        end
      end
      return res;
    endfunction

    // Move one channel a step toward black or white: red, green, blue
    function logic [23:0] step_extreme(logic [23:0] c, bit down);
      logic [23:0] res;
      logic [7:0]  cc;
      int          sh;
      res = c;
      for (int k = 0; k < 3; k++) begin
        sh = 16 - 8*k;
        cc = c[sh +: 8];
        if (down ? (cc != 8'd0) : (cc != pfe_pkg::WHITE)) begin
          res[sh +: 8] = down ? cc - pfe_pkg::STEP : cc + pfe_pkg::STEP;
          return res;
        end
      end
      return res;
    endfunction

    function void tick_bank(int unsigned b);
      int unsigned a;
      for (int unsigned i = rng_first; i <= rng_last; i++) begin
        a = b*ENTRIES + i;
        case (mode)
          pfe_pkg::FADE_IN:  cur_pal[a] = step_toward(cur_pal[a], tgt_pal[a], 1'b1);
          pfe_pkg::FADE_OUT: cur_pal[a] = step_extreme(cur_pal[a], 1'b1);
          pfe_pkg::FLASH_IN: cur_pal[a] = step_toward(cur_pal[a], tgt_pal[a], 1'b0);
          default:           cur_pal[a] = step_extreme(cur_pal[a], 1'b0);
        endcase
      end
    endfunction

    // Apply one accepted host word and queue the reply it must produce
    function void note_word(logic [2:0] action, host_word_t w);
      reply_t      r;
      int unsigned span_end;
      logic [6:0]  addr;
      r = '0;
      addr = {w.bank, w.entry};
      case (action)
        pfe_pkg::ACT_WR_CUR: cur_pal[addr] = {w.red, w.green, w.blue};
        pfe_pkg::ACT_WR_TGT: tgt_pal[addr] = {w.red, w.green, w.blue};
        pfe_pkg::ACT_RD_CUR: begin
          r.red   = cur_pal[addr][23:16];
          r.green = cur_pal[addr][15:8];
          r.blue  = cur_pal[addr][7:0];
        end
        pfe_pkg::ACT_START: begin
          if (w.fade_kind >= pfe_pkg::FADE_IN && w.fade_kind <= pfe_pkg::FLASH_OUT) begin
            if (w.fade_kind == pfe_pkg::FADE_IN) begin
              rng_first = w.first_entry;
              span_end = w.first_entry + w.last_offset;
              rng_last = (span_end > LAST_ENTRY) ? LAST_ENTRY : span_end;
              for (int unsigned i = rng_first; i <= rng_last; i++) cur_pal[i] = '0;
            end else begin
              rng_first = 0;
              rng_last = LAST_ENTRY;
              if (w.fade_kind == pfe_pkg::FLASH_IN)
                for (int i = 0; i < ENTRIES; i++)
                  cur_pal[i] = {pfe_pkg::WHITE, pfe_pkg::WHITE, pfe_pkg::WHITE};
            end
            mode = w.fade_kind;
            frames = 0;
          end
        end
        pfe_pkg::ACT_TICK: begin
          if (mode < pfe_pkg::FADE_IN || mode > pfe_pkg::FLASH_OUT) begin
            r.done = 1'b1;
          end else begin
            tick_bank(0);
            if (!((mode == pfe_pkg::FADE_IN || mode == pfe_pkg::FLASH_IN) && single_bank))
              tick_bank(1);
            frames++;
            if (frames >= FADE_TICKS) begin
              frames = 0;
              mode = pfe_pkg::FADE_NONE;
              r.done = 1'b1;
            end
          end
        end
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        flag($sformatf("reply with nothing outstanding: %h", got));
        return;
      end
      want = pending_replies.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.done !== want.done || got.fill !== '0)
        flag($sformatf("reply %0d: expected rgb %h %h %h done %b, got rgb %h %h %h done %b fill %h",
                       replies_seen, want.red, want.green, want.blue, want.done,
                       got.red, got.green, got.blue, got.done, got.fill));
      replies_seen++;
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fade_scoreboard sb = new();
  host_item_t     stim_words[$];
  bit             word_in_flight;
  int unsigned    rx_hold;

  palette_fade_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("[palette_fade_engine] ERROR");
    $finish;
  end

  // Word driver: pop queued host words, offer them in bursts with random gaps
  initial begin : word_driver
    host_item_t  item;
    int unsigned burst_left;
    int unsigned gap_left;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    word_in_flight = 1'b0;
    burst_left = 0;
    gap_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (gap_left != 0) begin
        s_axis_tvalid = 1'b0;
        gap_left--;
      end else if (stim_words.size() == 0) begin
        s_axis_tvalid = 1'b0;
      end else begin
        item = stim_words.pop_front();
        word_in_flight = 1'b1;
        s_axis_tdata = item.word;
        s_axis_tuser = item.action;
        s_axis_tvalid = 1'b1;
        do @(posedge clk_i); while (!s_axis_tready);
        sb.note_word(item.action, item.word);
        word_in_flight = 1'b0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Reply sink: ready pattern changes mode now and then; honor long hold-offs
  initial begin : reply_sink
    int unsigned mode_left;
    int unsigned pattern;
    int unsigned beat;
    m_axis_tready = 1'b0;
    rx_hold = 0;
    mode_left = 0;
    pattern = 0;
    beat = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        m_axis_tready = 1'b0;
        rx_hold--;
      end else begin
        if (mode_left == 0) begin
          pattern = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        beat++;
        case (pattern)
          0:       m_axis_tready = 1'b1;
          1:       m_axis_tready = $urandom_range(0, 1);
          default: m_axis_tready = (beat % 4 == 0);
        endcase
      end
    end
  end

  // Check every accepted reply word
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reply(m_axis_tdata);
  end

  function automatic logic [7:0] rand_channel();
    return ($urandom_range(0, 1) == 1) ? {3'($urandom_range(0, 7)), 5'd0} : 8'($urandom);
  endfunction

  function automatic host_word_t rand_word();
    host_word_t w;
    w = 48'($urandom) | (48'($urandom) << 32);
    w.fill = '0;
    w.red = rand_channel();
    w.green = rand_channel();
    w.blue = rand_channel();
    return w;
  endfunction

  function automatic host_word_t colour_word(logic b, logic [5:0] e, logic [7:0] r,
                                             logic [7:0] g, logic [7:0] bl);
    host_word_t w;
    w = rand_word();
    w.bank = b;
    w.entry = e;
    w.red = r;
    w.green = g;
    w.blue = bl;
    return w;
  endfunction

  function automatic host_word_t start_word(logic [2:0] kind, logic [5:0] first,
                                            logic [5:0] offs);
    host_word_t w;
    w = rand_word();
    w.fade_kind = kind;
    w.first_entry = first;
    w.last_offset = offs;
    return w;
  endfunction

  task automatic push_item(input logic [2:0] action, input host_word_t w);
    host_item_t item;
    item.action = action;
    item.word = w;
    stim_words.push_back(item);
  endtask

  // Hold until every queued word is accepted and every reply has come back
  task automatic wait_quiet();
    while (stim_words.size() != 0 || word_in_flight || sb.pending_replies.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [2:0] addr, input logic [31:0] data,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Write the single-bank register while idle and read it back
  task automatic set_single_bank(input bit v);
    logic [31:0] rd;
    wait_quiet();
    apb_access(1'b1, REG_ADDR, {31'd0, v}, rd);
    sb.single_bank = v;
    apb_access(1'b0, REG_ADDR, '0, rd);
    if (rd !== {31'd0, v})
      sb.flag($sformatf("register read: expected %h, got %h", {31'd0, v}, rd));
  endtask

  // Mostly fade runs (start then ticks with host traffic mixed in), some noise
  task automatic fill_phase(input int unsigned count);
    int unsigned pushed;
    int unsigned len;
    int unsigned pick;
    pushed = 0;
    while (pushed < count) begin
      if ($urandom_range(0, 9) < 7) begin
        push_item(pfe_pkg::ACT_START, start_word(3'($urandom_range(1, 4)), 6'($urandom),
                                                 6'($urandom)));
        len = $urandom_range(18, 30);
        for (int unsigned k = 0; k < len; k++) begin
          pick = $urandom_range(0, 99);
          if (pick < 78)      push_item(pfe_pkg::ACT_TICK, rand_word());
          else if (pick < 86) push_item(pfe_pkg::ACT_RD_CUR, rand_word());
          else if (pick < 92) push_item(pfe_pkg::ACT_WR_CUR, rand_word());
          else if (pick < 97) push_item(pfe_pkg::ACT_WR_TGT, rand_word());
          else                push_item(3'($urandom_range(0, 7)), rand_word());
        end
        pushed += len + 1;
      end else begin
        len = $urandom_range(3, 10);
        for (int unsigned k = 0; k < len; k++)
          push_item(3'($urandom_range(0, 7)), rand_word());
        pushed += len;
      end
    end
  endtask

  initial begin : main_seq
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    set_single_bank(1'b0);

    // Fill both banks, current and target, so nothing undefined is ever read or faded
    for (int b = 0; b < 2; b++) begin
      for (int e = 0; e < ENTRIES; e++) begin
        push_item(pfe_pkg::ACT_WR_CUR, colour_word(b[0], e[5:0], rand_channel(),
                                                   rand_channel(), rand_channel()));
        push_item(pfe_pkg::ACT_WR_TGT, colour_word(b[0], e[5:0], rand_channel(),
                                                   rand_channel(), rand_channel()));
      end
    end

    // Extreme colours, idle tick, ignored actions and kinds
    push_item(pfe_pkg::ACT_WR_CUR, colour_word(1'b0, 6'd0, 8'hFF, 8'hFF, 8'hFF));
    push_item(pfe_pkg::ACT_WR_CUR, colour_word(1'b1, 6'd63, 8'h00, 8'h00, 8'h00));
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b0, 6'd0, 8'h00, 8'h00, 8'h00));
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b1, 6'd63, 8'hFF, 8'hFF, 8'hFF));
    push_item(pfe_pkg::ACT_WR_TGT, colour_word(1'b1, 6'd63, 8'hFF, 8'h00, 8'hFF));
    push_item(pfe_pkg::ACT_TICK, rand_word());
    push_item(ACT_SPARE_LO, rand_word());
    push_item(ACT_SPARE_HI, rand_word());
    push_item(pfe_pkg::ACT_START, start_word(pfe_pkg::FADE_NONE, 6'd5, 6'd5));
    push_item(pfe_pkg::ACT_START, start_word(KIND_SPARE_HI, 6'd5, 6'd5));
    push_item(pfe_pkg::ACT_TICK, rand_word());

    // Fade-in whose range runs past the last entry
    push_item(pfe_pkg::ACT_START, start_word(pfe_pkg::FADE_IN, 6'd60, 6'd63));
    push_item(pfe_pkg::ACT_TICK, rand_word());
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b0, 6'd61, 8'h00, 8'h00, 8'h00));
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b1, 6'd63, 8'h00, 8'h00, 8'h00));
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b0, 6'd59, 8'h00, 8'h00, 8'h00));

    // Single-bank flash-in, then the two full-range kinds
    set_single_bank(1'b1);
    push_item(pfe_pkg::ACT_START, start_word(pfe_pkg::FLASH_IN, 6'd0, 6'd0));
    push_item(pfe_pkg::ACT_TICK, rand_word());
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b0, 6'd0, 8'h00, 8'h00, 8'h00));
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b1, 6'd63, 8'h00, 8'h00, 8'h00));
    push_item(pfe_pkg::ACT_START, start_word(pfe_pkg::FADE_OUT, 6'd63, 6'd0));
    push_item(pfe_pkg::ACT_TICK, rand_word());
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b1, 6'd63, 8'h00, 8'h00, 8'h00));
    push_item(pfe_pkg::ACT_START, start_word(pfe_pkg::FLASH_OUT, 6'd0, 6'd63));
    push_item(pfe_pkg::ACT_TICK, rand_word());
    push_item(pfe_pkg::ACT_RD_CUR, colour_word(1'b0, 6'd0, 8'h00, 8'h00, 8'h00));

    // Random phases under both register settings
    for (int phase = 0; phase < 4; phase++) begin
      set_single_bank(phase == 1 || phase == 2);
      if (phase == 2) begin
        // Let the sender stop until every reply is back, then resume
        fill_phase(PHASE_WORDS / 2);
        wait_quiet();
        fill_phase(PHASE_WORDS / 2);
      end else begin
        fill_phase(PHASE_WORDS);
      end
      // Long receiver hold-off while the sender keeps offering
      if (phase == 1) rx_hold = 900;
    end

    wait_quiet();
    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("[palette_fade_engine] OK");
    end else begin
      $display("[palette_fade_engine] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pfe_pkg.sv
sv/pfe_ram.sv
sv/pfe_ctrl.sv
sv/pfe_dpath.sv
sv/palette_fade_engine.sv
tb/palette_fade_engine_tb.sv
